// ----- sv/mfcd_pkg.sv -----
// Shared types, codes and saturation helpers for the masked factor
// coordinate descent unit. No dependencies.
package mfcd_pkg;

   localparam int ROWS_DEF    = 256;
   localparam int COLS_DEF    = 64;
   localparam int BASIS_DEF   = 8;
   localparam int FACTORS_DEF = 8;

   localparam int MUL_W       = 34;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_USED    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_USED    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASIS_USED   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FACTORS_USED = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SIZE    = 3'd4;

   localparam logic [31:0] STEP_RESET = 32'd42950;

   localparam logic [2:0] OP_LOAD_DATA   = 3'd0;
   localparam logic [2:0] OP_LOAD_BASIS  = 3'd1;
   localparam logic [2:0] OP_LOAD_MIXING = 3'd2;
   localparam logic [2:0] OP_LOAD_COEF   = 3'd3;
   localparam logic [2:0] OP_UPDATE      = 3'd4;
   localparam logic [2:0] OP_READ_COEF   = 3'd5;

   localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

   // Index width for a dimension of n entries, at least one bit.
   function automatic int idx_w(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > SAT_HI) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < SAT_LO) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [63:0] sext32(input logic signed [31:0] x);
      return {{32{x[31]}}, x};
   endfunction

endpackage

// ----- sv/mfcd_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on mfcd_pkg for the operand width.
module mfcd_mul (
   input  logic                                 clock,
   input  logic signed [mfcd_pkg::MUL_W-1:0]    op_a,
   input  logic signed [mfcd_pkg::MUL_W-1:0]    op_b,
   output logic signed [2*mfcd_pkg::MUL_W-1:0]  prod
);
   import mfcd_pkg::*;

   logic signed [2*MUL_W-1:0] prod_ff;
   logic signed [2*MUL_W-1:0] prod_in;

   assign prod_in = op_a * op_b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- sv/mfcd_engine.sv -----
// Sequencer and matrix stores: loads, residual rebuild, gradient step,
// coefficient update and energy pass. Depends on mfcd_pkg and mfcd_mul.
module mfcd_engine #(
   parameter int ROWS_MAX    = 256,
   parameter int COLS_MAX    = 64,
   parameter int BASIS_MAX   = 8,
   parameter int FACTORS_MAX = 8
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [2:0]                                opcode,
   input  logic [7:0]                                row,
   input  logic [5:0]                                col,
   input  logic signed [31:0]                        value,
   input  logic                                      present,
   input  logic [mfcd_pkg::idx_w(ROWS_MAX)-1:0]      rows_last,
   input  logic [mfcd_pkg::idx_w(COLS_MAX)-1:0]      cols_last,
   input  logic [mfcd_pkg::idx_w(BASIS_MAX)-1:0]     basis_last,
   input  logic [mfcd_pkg::idx_w(FACTORS_MAX)-1:0]   factors_last,
   input  logic [31:0]                               step,
   input  logic                                      out_free,
   output logic                                      idle,
   output logic                                      res_push,
   output logic signed [31:0]                        res_coef,
   output logic [62:0]                               res_energy,
   output logic                                      res_is_energy
);
   import mfcd_pkg::*;

   localparam int RW = idx_w(ROWS_MAX);
   localparam int CW = idx_w(COLS_MAX);
   localparam int BW = idx_w(BASIS_MAX);
   localparam int FW = idx_w(FACTORS_MAX);

   typedef enum logic [3:0] {
      S_IDLE, S_RD1, S_RD2, S_HB, S_FIT, S_RES, S_EN,
      S_GT, S_GB, S_DLO, S_DHI, S_CWR, S_OUT
   } state_type;

   // Stores.
   logic [32:0]        data_mem  [2**(RW+CW)];
   logic signed [31:0] res_mem   [2**(RW+CW)];
   logic signed [31:0] basis_mem [2**(RW+BW)];
   logic signed [31:0] mix_mem   [2**(CW+FW)];
   logic signed [31:0] coef_mem  [2**(BW+FW)];

   logic [32:0]        data_rd_ff;
   logic signed [31:0] res_rd_ff, basis_rd_ff, mix_rd_ff, coef_rd_ff;

   logic                  data_we, res_we, basis_we, mix_we, coef_we;
   logic [RW+CW-1:0]      data_waddr;
   logic [RW+BW-1:0]      basis_waddr;
   logic [CW+FW-1:0]      mix_waddr;
   logic [BW+FW-1:0]      coef_waddr;
   logic signed [31:0]    res_wdata, coef_wdata;

   // Control and datapath registers.
   state_type          state_ff, state_in;
   logic [1:0]         ph_ff, ph_in;
   logic               rebuild_ff, rebuild_in;
   logic [RW-1:0]      i_ff, i_in;
   logic [CW-1:0]      j_ff, j_in;
   logic [FW-1:0]      k_ff, k_in, sf_ff, sf_in, sf_c;
   logic [BW-1:0]      l_ff, l_in, sb_ff, sb_in, sb_c;
   logic signed [63:0] acc_ff, acc_in, g_ff, g_in;
   logic [63:0]        energy_ff, energy_in;
   logic signed [31:0] fit_ff, fit_in, t_ff, t_in;
   logic [32:0]        mag_ff, mag_in;
   logic signed [31:0] hb_ff [FACTORS_MAX];
   logic signed [31:0] hb_in [FACTORS_MAX];
   logic               okay_ff, okay_in;
   logic signed [31:0] out_coef_ff, out_coef_in;
   logic [62:0]        out_energy_ff, out_energy_in;
   logic               out_is_e_ff, out_is_e_in;

   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] prod;
   logic signed [2*MUL_W-1:0] prod_sh;
   logic signed [63:0]        prod_s24, acc_sum;
   logic signed [32:0]        diff;
   logic                      mac_last, adv_j, fit_go, grad_go, push;

   mfcd_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign prod_sh  = prod >>> 24;
   assign prod_s24 = $signed(prod_sh[63:0]);
   assign acc_sum  = acc_ff + prod_s24;
   assign mac_last = (ph_ff == 2'd2);
   assign diff     = $signed({data_rd_ff[31], data_rd_ff[31:0]})
                   - $signed({fit_ff[31], fit_ff});

   // A sweep position left beyond the used sizes restarts at the origin.
   assign sb_c = (sb_ff > basis_last || sf_ff > factors_last) ? '0 : sb_ff;
   assign sf_c = (sb_ff > basis_last || sf_ff > factors_last) ? '0 : sf_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_HB: begin
            mul_a = MUL_W'(basis_rd_ff);
            mul_b = MUL_W'(coef_rd_ff);
         end
         S_FIT: begin
            mul_a = MUL_W'(hb_ff[k_ff]);
            mul_b = MUL_W'(mix_rd_ff);
         end
         S_EN: begin
            mul_a = $signed({1'b0, mag_ff});
            mul_b = $signed({1'b0, mag_ff});
         end
         S_GT: begin
            mul_a = MUL_W'(res_rd_ff);
            mul_b = MUL_W'(mix_rd_ff);
         end
         S_GB: begin
            mul_a = MUL_W'(basis_rd_ff);
            mul_b = MUL_W'(t_ff);
         end
         S_DLO: begin
            mul_a = $signed({2'b00, step});
            mul_b = $signed({2'b00, g_ff[31:0]});
         end
         S_DHI: begin
            mul_a = $signed({2'b00, step});
            mul_b = $signed({{2{g_ff[63]}}, g_ff[63:32]});
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      ph_in         = ph_ff;
      rebuild_in    = rebuild_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      l_in          = l_ff;
      sb_in         = sb_ff;
      sf_in         = sf_ff;
      acc_in        = acc_ff;
      g_in          = g_ff;
      energy_in     = energy_ff;
      fit_in        = fit_ff;
      t_in          = t_ff;
      mag_in        = mag_ff;
      hb_in         = hb_ff;
      okay_in       = okay_ff;
      out_coef_in   = out_coef_ff;
      out_energy_in = out_energy_ff;
      out_is_e_in   = out_is_e_ff;
      data_we       = 1'b0;
      res_we        = 1'b0;
      basis_we      = 1'b0;
      mix_we        = 1'b0;
      coef_we       = 1'b0;
      data_waddr    = {RW'(row), CW'(col)};
      basis_waddr   = {RW'(row), BW'(col)};
      mix_waddr     = {CW'(row), FW'(col)};
      coef_waddr    = {BW'(row), FW'(col)};
      res_wdata     = '0;
      coef_wdata    = value;
      adv_j         = 1'b0;
      fit_go        = 1'b0;
      grad_go       = 1'b0;
      push          = 1'b0;

      if (state_ff == S_HB || state_ff == S_FIT || state_ff == S_EN ||
          state_ff == S_GT || state_ff == S_GB || state_ff == S_DLO ||
          state_ff == S_DHI) begin
         ph_in = mac_last ? 2'd0 : ph_ff + 2'd1;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (opcode)
                  OP_LOAD_DATA:   data_we  = (row < ROWS_MAX) && (col < COLS_MAX);
                  OP_LOAD_BASIS:  basis_we = (row < ROWS_MAX) && (col < BASIS_MAX);
                  OP_LOAD_MIXING: mix_we   = (row < COLS_MAX) && (col < FACTORS_MAX);
                  OP_LOAD_COEF:   coef_we  = (row < BASIS_MAX) && (col < FACTORS_MAX);
                  OP_UPDATE: begin
                     sb_in = sb_c;
                     sf_in = sf_c;
                     if (sb_c == '0 && sf_c == '0) begin
                        rebuild_in = 1'b1;
                        fit_go     = 1'b1;
                     end else begin
                        grad_go = 1'b1;
                     end
                  end
                  OP_READ_COEF: begin
                     l_in     = BW'(row);
                     k_in     = FW'(col);
                     okay_in  = (row < BASIS_MAX) && (col < FACTORS_MAX);
                     state_in = S_RD1;
                  end
                  default: ;
               endcase
            end
         end
         S_RD1: state_in = S_RD2;
         S_RD2: begin
            out_coef_in   = okay_ff ? coef_rd_ff : '0;
            out_energy_in = '0;
            out_is_e_in   = 1'b0;
            state_in      = S_OUT;
         end
         S_HB: begin
            if (mac_last) begin
               if (l_ff == basis_last) begin
                  hb_in[k_ff] = sat32(acc_sum);
                  acc_in      = '0;
                  l_in        = '0;
                  if (k_ff == factors_last) begin
                     k_in     = '0;
                     j_in     = '0;
                     state_in = S_FIT;
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end else begin
                  acc_in = acc_sum;
                  l_in   = l_ff + 1'b1;
               end
            end
         end
         S_FIT: begin
            if (mac_last) begin
               if (k_ff == factors_last) begin
                  fit_in   = sat32(acc_sum);
                  acc_in   = '0;
                  k_in     = '0;
                  state_in = S_RES;
               end else begin
                  acc_in = acc_sum;
                  k_in   = k_ff + 1'b1;
               end
            end
         end
         S_RES: begin
            if (rebuild_ff) begin
               res_we    = 1'b1;
               res_wdata = data_rd_ff[32] ?
                           sat32({{30{diff[32]}}, diff, 1'b0}) : '0;
               adv_j     = 1'b1;
            end else if (data_rd_ff[32]) begin
               mag_in   = diff[32] ? 33'(-diff) : 33'(diff);
               state_in = S_EN;
            end else begin
               adv_j = 1'b1;
            end
         end
         S_EN: begin
            if (mac_last) begin
               energy_in = energy_ff + 64'(prod_s24);
               adv_j     = 1'b1;
            end
         end
         S_GT: begin
            if (mac_last) begin
               if (j_ff == cols_last) begin
                  t_in     = sat32(acc_sum);
                  acc_in   = '0;
                  j_in     = '0;
                  state_in = S_GB;
               end else begin
                  acc_in = acc_sum;
                  j_in   = j_ff + 1'b1;
               end
            end
         end
         S_GB: begin
            if (mac_last) begin
               g_in = g_ff + prod_s24;
               if (i_ff == rows_last) begin
                  state_in = S_DLO;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_GT;
               end
            end
         end
         S_DLO: begin
            if (mac_last) begin
               acc_in   = $signed({28'd0, prod[67:32]});
               state_in = S_DHI;
            end
         end
         S_DHI: begin
            if (mac_last) begin
               acc_in   = acc_ff + $signed(prod[63:0]);
               state_in = S_CWR;
            end
         end
         S_CWR: begin
            coef_we    = 1'b1;
            coef_waddr = {l_ff, k_ff};
            coef_wdata = sat32(sext32(coef_rd_ff) + acc_ff);
            if (sf_ff == factors_last) begin
               sf_in = '0;
               sb_in = (sb_ff == basis_last) ? '0 : sb_ff + 1'b1;
            end else begin
               sf_in = sf_ff + 1'b1;
            end
            rebuild_in = 1'b0;
            energy_in  = '0;
            fit_go     = 1'b1;
         end
         S_OUT: begin
            if (out_free) begin
               push     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Step to the next data column of a fit pass.
      if (adv_j) begin
         if (j_ff == cols_last) begin
            j_in = '0;
            if (i_ff == rows_last) begin
               if (rebuild_ff) begin
                  grad_go = 1'b1;
               end else begin
                  out_coef_in   = '0;
                  out_energy_in = energy_in[63] ? '1 : energy_in[62:0];
                  out_is_e_in   = 1'b1;
                  state_in      = S_OUT;
               end
            end else begin
               i_in     = i_ff + 1'b1;
               k_in     = '0;
               l_in     = '0;
               state_in = S_HB;
            end
         end else begin
            j_in     = j_ff + 1'b1;
            k_in     = '0;
            state_in = S_FIT;
         end
      end

      if (fit_go) begin
         i_in     = '0;
         j_in     = '0;
         k_in     = '0;
         l_in     = '0;
         acc_in   = '0;
         ph_in    = 2'd0;
         state_in = S_HB;
      end

      if (grad_go) begin
         i_in     = '0;
         j_in     = '0;
         l_in     = sb_in;
         k_in     = sf_in;
         acc_in   = '0;
         g_in     = '0;
         ph_in    = 2'd0;
         state_in = S_GT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ph_ff    <= 2'd0;
         sb_ff    <= '0;
         sf_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         sb_ff    <= sb_in;
         sf_ff    <= sf_in;
      end
      rebuild_ff    <= rebuild_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      l_ff          <= l_in;
      acc_ff        <= acc_in;
      g_ff          <= g_in;
      energy_ff     <= energy_in;
      fit_ff        <= fit_in;
      t_ff          <= t_in;
      mag_ff        <= mag_in;
      hb_ff         <= hb_in;
      okay_ff       <= okay_in;
      out_coef_ff   <= out_coef_in;
      out_energy_ff <= out_energy_in;
      out_is_e_ff   <= out_is_e_in;
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_waddr] <= {present, value};
      end
      if (res_we) begin
         res_mem[{i_ff, j_ff}] <= res_wdata;
      end
      if (basis_we) begin
         basis_mem[basis_waddr] <= value;
      end
      if (mix_we) begin
         mix_mem[mix_waddr] <= value;
      end
      if (coef_we) begin
         coef_mem[coef_waddr] <= coef_wdata;
      end
      data_rd_ff  <= data_mem[{i_ff, j_ff}];
      res_rd_ff   <= res_mem[{i_ff, j_ff}];
      basis_rd_ff <= basis_mem[{i_ff, l_ff}];
      mix_rd_ff   <= mix_mem[{j_ff, k_ff}];
      coef_rd_ff  <= coef_mem[{l_ff, k_ff}];
   end

   assign idle          = (state_ff == S_IDLE);
   assign res_push      = push;
   assign res_coef      = out_coef_ff;
   assign res_energy    = out_energy_ff;
   assign res_is_energy = out_is_e_ff;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      ph_ff != 2'd3) else $error("MAC phase counter out of range");

   a_coord_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CWR |-> (l_ff == sb_ff && k_ff == sf_ff))
      else $error("coefficient written at a position other than the sweep point");

   a_res_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RES |-> ph_ff == 2'd0)
      else $error("fit finished mid multiply");

   a_push_idle: assert property (@(posedge clock) disable iff (reset)
      push |=> state_ff == S_IDLE)
      else $error("engine not idle after handing over a result");

endmodule

// ----- sv/masked_factor_coordinate_descent_unit.sv -----
// Top level: configuration registers, request/response handshake and
// output register. Depends on mfcd_pkg and mfcd_engine.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_ready  | opcode, row/col index, entry value, present
//  rsp     | out | rsp_valid/rsp_ready  | coefficient, residual energy, is_energy
//  csr     | in  | csr_we               | csr_index, csr_wdata
//
// Loads are written straight from the idle state; a coefficient read passes S_RD1 and S_RD2.
// An update runs the residual rebuild at the first coordinate of a sweep, then the gradient,
// the coefficient write, the energy pass over the present entries in use and the hand-over;
// one shared multiplier serves every product. Reset is synchronous and clears only control
// state. A finished result waits in the output register while the next transfer is taken.
module masked_factor_coordinate_descent_unit #(
   parameter int ROWS_MAX    = mfcd_pkg::ROWS_DEF,
   parameter int COLS_MAX    = mfcd_pkg::COLS_DEF,
   parameter int BASIS_MAX   = mfcd_pkg::BASIS_DEF,
   parameter int FACTORS_MAX = mfcd_pkg::FACTORS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [2:0]                            req_opcode,
   input  logic [7:0]                            req_row_index,
   input  logic [5:0]                            req_col_index,
   input  logic signed [31:0]                    req_entry_value,
   input  logic                                  req_present,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [31:0]                    rsp_coefficient,
   output logic [62:0]                           rsp_residual_energy,
   output logic                                  rsp_is_energy,
   input  logic                                  csr_we,
   input  logic [mfcd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mfcd_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import mfcd_pkg::*;

   localparam int RW = idx_w(ROWS_MAX);
   localparam int CW = idx_w(COLS_MAX);
   localparam int BW = idx_w(BASIS_MAX);
   localparam int FW = idx_w(FACTORS_MAX);

   logic [RW-1:0] rows_last_ff, rows_last_in;
   logic [CW-1:0] cols_last_ff, cols_last_in;
   logic [BW-1:0] basis_last_ff, basis_last_in;
   logic [FW-1:0] factors_last_ff, factors_last_in;
   logic [31:0]   step_ff, step_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_coef_ff, rsp_coef_in;
   logic [62:0]        rsp_energy_ff, rsp_energy_in;
   logic               rsp_is_e_ff, rsp_is_e_in;

   logic               idle, push, out_free, start;
   logic signed [31:0] res_coef;
   logic [62:0]        res_energy;
   logic               res_is_energy;

   // Register value zero acts as one, above the maximum as the maximum.
   function automatic logic [15:0] clamp_last(input logic [15:0] v, input int max_v);
      logic [15:0] r;
      if (v == 16'd0) begin
         r = 16'd0;
      end else if (v > max_v) begin
         r = 16'(max_v - 1);
      end else begin
         r = v - 16'd1;
      end
      return r;
   endfunction

   always_comb begin
      rows_last_in    = rows_last_ff;
      cols_last_in    = cols_last_ff;
      basis_last_in   = basis_last_ff;
      factors_last_in = factors_last_ff;
      step_in         = step_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROWS_USED:
               rows_last_in = RW'(clamp_last({7'd0, csr_wdata[8:0]}, ROWS_MAX));
            CSR_COLS_USED:
               cols_last_in = CW'(clamp_last({9'd0, csr_wdata[6:0]}, COLS_MAX));
            CSR_BASIS_USED:
               basis_last_in = BW'(clamp_last({12'd0, csr_wdata[3:0]}, BASIS_MAX));
            CSR_FACTORS_USED:
               factors_last_in = FW'(clamp_last({12'd0, csr_wdata[3:0]}, FACTORS_MAX));
            CSR_STEP_SIZE:
               step_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign start    = req_valid && idle;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_coef_in   = rsp_coef_ff;
      rsp_energy_in = rsp_energy_ff;
      rsp_is_e_in   = rsp_is_e_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (push) begin
         rsp_valid_in  = 1'b1;
         rsp_coef_in   = res_coef;
         rsp_energy_in = res_energy;
         rsp_is_e_in   = res_is_energy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_last_ff    <= RW'(ROWS_MAX - 1);
         cols_last_ff    <= CW'(COLS_MAX - 1);
         basis_last_ff   <= BW'(BASIS_MAX - 1);
         factors_last_ff <= FW'(FACTORS_MAX - 1);
         step_ff         <= STEP_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rows_last_ff    <= rows_last_in;
         cols_last_ff    <= cols_last_in;
         basis_last_ff   <= basis_last_in;
         factors_last_ff <= factors_last_in;
         step_ff         <= step_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_coef_ff   <= rsp_coef_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_is_e_ff   <= rsp_is_e_in;
   end

   mfcd_engine #(
      .ROWS_MAX    (ROWS_MAX),
      .COLS_MAX    (COLS_MAX),
      .BASIS_MAX   (BASIS_MAX),
      .FACTORS_MAX (FACTORS_MAX)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .opcode        (req_opcode),
      .row           (req_row_index),
      .col           (req_col_index),
      .value         (req_entry_value),
      .present       (req_present),
      .rows_last     (rows_last_ff),
      .cols_last     (cols_last_ff),
      .basis_last    (basis_last_ff),
      .factors_last  (factors_last_ff),
      .step          (step_ff),
      .out_free      (out_free),
      .idle          (idle),
      .res_push      (push),
      .res_coef      (res_coef),
      .res_energy    (res_energy),
      .res_is_energy (res_is_energy)
   );

   assign req_ready           = idle;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_coefficient     = rsp_coef_ff;
   assign rsp_residual_energy = rsp_energy_ff;
   assign rsp_is_energy       = rsp_is_e_ff;

endmodule
